// ===== sv/mqts_pkg.sv =====
// Shared types and codes for the min queue (two-stack FIFO with minimum).
// Used by mqts_if, mqts_ctrl, mqts_dp and min_queue_two_stacks_core.
// No dependencies.
package mqts_pkg;

   localparam int IoWidth = 32;

   typedef logic [2:0] cmd_type;
   localparam cmd_type CMD_ENQUEUE = 3'd0;
   localparam cmd_type CMD_DEQUEUE = 3'd1;
   localparam cmd_type CMD_FRONT   = 3'd2;
   localparam cmd_type CMD_SIZE    = 3'd3;
   localparam cmd_type CMD_CLEAR   = 3'd4;
   localparam cmd_type CMD_MIN     = 3'd5;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_VALUE = 2'd1;
   localparam status_type STATUS_EMPTY = 2'd2;
   localparam status_type STATUS_FULL  = 2'd3;

   // what the datapath puts in the response register
   typedef enum logic [2:0] {
      RSP_OK,
      RSP_FULL,
      RSP_EMPTY,
      RSP_TOP,
      RSP_MIN
   } rsp_sel_type;

   typedef struct packed {
      logic        load_in;     // capture the request value
      logic        rd_out_top;  // read out-stack top entry
      logic        push_in;     // push captured value on in-stack
      logic        pop_out;     // drop out-stack top
      logic        rd_in_top;   // read and pop in-stack top
      logic        push_reloc;  // push last in-stack read onto out-stack
      logic        clear;
      logic        rsp_load;
      rsp_sel_type rsp_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic in_empty;
      logic out_empty;
      logic q_empty;
      logic q_full;
   } dp_status_type;

endpackage

// ===== sv/mqts_if.sv =====
// Request and response channel interfaces of the min queue.
// Depends on mqts_pkg.
interface mqts_req_if;
   logic                            valid;
   logic                            ready;
   mqts_pkg::cmd_type               cmd;
   logic signed [mqts_pkg::IoWidth-1:0] data_in;

   modport source (output valid, output cmd, output data_in, input ready);
   modport sink (input valid, input cmd, input data_in, output ready);
endinterface

interface mqts_rsp_if #(parameter int COUNT_WIDTH = 11);
   logic                            valid;
   logic                            ready;
   mqts_pkg::status_type            status;
   logic signed [mqts_pkg::IoWidth-1:0] data_out;
   logic [COUNT_WIDTH-1:0]          count;

   modport source (output valid, output status, output data_out, output count, input ready);
   modport sink (input valid, input status, input data_out, input count, output ready);
endinterface

// ===== sv/mqts_ctrl.sv =====
// Controller of the min queue: command sequencing, stack relocation and
// response handshake. Depends on mqts_pkg; drives mqts_dp.
module mqts_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  mqts_pkg::cmd_type       req_cmd,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output mqts_pkg::dp_cmd_type    dp_cmd,
   input  mqts_pkg::dp_status_type dp_status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RELOC,
      ST_FETCH
   } state_type;

   state_type         state_ff, state_in;
   mqts_pkg::cmd_type cmd_ff, cmd_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              slot_free;

   assign slot_free = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      req_ready      = 1'b0;
      dp_cmd         = '0;
      dp_cmd.rsp_sel = mqts_pkg::RSP_OK;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in            = req_cmd;
               dp_cmd.load_in    = 1'b1;
               dp_cmd.rd_out_top = 1'b1;
               state_in          = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (slot_free) begin
               state_in        = ST_IDLE;
               dp_cmd.rsp_load = 1'b1;
               rsp_valid_in    = 1'b1;
               case (cmd_ff)
                  mqts_pkg::CMD_ENQUEUE: begin
                     if (dp_status.q_full) begin
                        dp_cmd.rsp_sel = mqts_pkg::RSP_FULL;
                     end else begin
                        dp_cmd.push_in = 1'b1;
                     end
                  end
                  mqts_pkg::CMD_DEQUEUE, mqts_pkg::CMD_FRONT: begin
                     if (dp_status.q_empty) begin
                        dp_cmd.rsp_sel = mqts_pkg::RSP_EMPTY;
                     end else if (dp_status.out_empty) begin
                        // move the in-stack over, then retry this transaction
                        dp_cmd.rsp_load  = 1'b0;
                        rsp_valid_in     = rsp_valid_ff & ~rsp_ready;
                        dp_cmd.rd_in_top = 1'b1;
                        state_in         = ST_RELOC;
                     end else begin
                        dp_cmd.rsp_sel = mqts_pkg::RSP_TOP;
                        dp_cmd.pop_out = (cmd_ff == mqts_pkg::CMD_DEQUEUE);
                     end
                  end
                  mqts_pkg::CMD_CLEAR: begin
                     dp_cmd.clear = 1'b1;
                  end
                  mqts_pkg::CMD_MIN: begin
                     dp_cmd.rsp_sel = dp_status.q_empty ? mqts_pkg::RSP_EMPTY
                                                        : mqts_pkg::RSP_MIN;
                  end
                  default: begin
                     dp_cmd.rsp_sel = mqts_pkg::RSP_OK;
                  end
               endcase
            end
         end
         ST_RELOC: begin
            // one entry per cycle: push the last read, read the next
            dp_cmd.push_reloc = 1'b1;
            if (dp_status.in_empty) begin
               state_in = ST_FETCH;
            end else begin
               dp_cmd.rd_in_top = 1'b1;
            end
         end
         ST_FETCH: begin
            dp_cmd.rd_out_top = 1'b1;
            state_in          = ST_EXEC;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmd_ff       <= mqts_pkg::CMD_SIZE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmd_ff       <= cmd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/mqts_dp.sv =====
// Datapath of the min queue: the two stack memories (value and running
// minimum per entry), stack counts and the response register.
// Depends on mqts_pkg; controlled by mqts_ctrl.
module mqts_dp #(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32,
   localparam int CountWidth = $clog2(DEPTH + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [mqts_pkg::IoWidth-1:0]     req_data_in,
   input  mqts_pkg::dp_cmd_type             dp_cmd,
   output mqts_pkg::dp_status_type          dp_status,
   output mqts_pkg::status_type             rsp_status,
   output logic signed [mqts_pkg::IoWidth-1:0] rsp_data_out,
   output logic [CountWidth-1:0]            rsp_count
);

   localparam int AddrWidth  = $clog2(DEPTH);
   localparam int EntryWidth = 2 * DATA_WIDTH;

   function automatic logic [DATA_WIDTH-1:0] smin(input logic [DATA_WIDTH-1:0] a,
                                                 input logic [DATA_WIDTH-1:0] b);
      return ($signed(b) < $signed(a)) ? b : a;
   endfunction

   logic [EntryWidth-1:0]  in_mem  [DEPTH];
   logic [EntryWidth-1:0]  out_mem [DEPTH];
   logic [EntryWidth-1:0]  in_rd_ff, out_rd_ff;

   logic [CountWidth-1:0]  in_count_ff, in_count_in, out_count_ff, out_count_in;
   logic [CountWidth-1:0]  total, in_count_m1, out_count_m1;
   logic [DATA_WIDTH-1:0]  value_ff;
   logic [DATA_WIDTH-1:0]  in_min_ff, in_push_min;
   logic [DATA_WIDTH-1:0]  reloc_min_ff, reloc_val, reloc_push_min;
   logic [DATA_WIDTH-1:0]  top_val, top_min, queue_min;

   mqts_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic signed [mqts_pkg::IoWidth-1:0] rsp_data_ff, rsp_data_in;
   logic [CountWidth-1:0]             rsp_count_ff;
   logic signed [DATA_WIDTH-1:0]      sel_val;

   assign total        = in_count_ff + out_count_ff;
   assign in_count_m1  = in_count_ff - CountWidth'(1);
   assign out_count_m1 = out_count_ff - CountWidth'(1);

   assign dp_status.in_empty  = (in_count_ff == '0);
   assign dp_status.out_empty = (out_count_ff == '0);
   assign dp_status.q_empty   = (total == '0);
   assign dp_status.q_full    = (total == CountWidth'(DEPTH));

   assign in_push_min    = dp_status.in_empty ? value_ff : smin(in_min_ff, value_ff);
   assign reloc_val      = in_rd_ff[EntryWidth-1:DATA_WIDTH];
   assign reloc_push_min = dp_status.out_empty ? reloc_val : smin(reloc_min_ff, reloc_val);
   assign top_val        = out_rd_ff[EntryWidth-1:DATA_WIDTH];
   assign top_min        = out_rd_ff[DATA_WIDTH-1:0];

   always_comb begin
      if (dp_status.in_empty) begin
         queue_min = top_min;
      end else if (dp_status.out_empty) begin
         queue_min = in_min_ff;
      end else begin
         queue_min = smin(in_min_ff, top_min);
      end
   end

   always_comb begin
      in_count_in  = in_count_ff;
      out_count_in = out_count_ff;
      if (dp_cmd.clear) begin
         in_count_in  = '0;
         out_count_in = '0;
      end else begin
         if (dp_cmd.push_in)    in_count_in  = in_count_ff + CountWidth'(1);
         if (dp_cmd.rd_in_top)  in_count_in  = in_count_m1;
         if (dp_cmd.push_reloc) out_count_in = out_count_ff + CountWidth'(1);
         if (dp_cmd.pop_out)    out_count_in = out_count_m1;
      end
   end

   always_comb begin
      rsp_status_in = mqts_pkg::STATUS_OK;
      sel_val       = '0;
      case (dp_cmd.rsp_sel)
         mqts_pkg::RSP_FULL:  rsp_status_in = mqts_pkg::STATUS_FULL;
         mqts_pkg::RSP_EMPTY: rsp_status_in = mqts_pkg::STATUS_EMPTY;
         mqts_pkg::RSP_TOP: begin
            rsp_status_in = mqts_pkg::STATUS_VALUE;
            sel_val       = top_val;
         end
         mqts_pkg::RSP_MIN: begin
            rsp_status_in = mqts_pkg::STATUS_VALUE;
            sel_val       = queue_min;
         end
         default: rsp_status_in = mqts_pkg::STATUS_OK;
      endcase
      // sign-extend from the stored width
      rsp_data_in = mqts_pkg::IoWidth'(sel_val);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_count_ff  <= '0;
         out_count_ff <= '0;
      end else begin
         in_count_ff  <= in_count_in;
         out_count_ff <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load_in) value_ff <= DATA_WIDTH'(req_data_in);
      if (dp_cmd.push_in) in_min_ff <= in_push_min;
      if (dp_cmd.push_reloc) reloc_min_ff <= reloc_push_min;
      if (dp_cmd.rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_count_ff  <= in_count_in + out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.push_in) begin
         in_mem[in_count_ff[AddrWidth-1:0]] <= {value_ff, in_push_min};
      end
      if (dp_cmd.rd_in_top) begin
         in_rd_ff <= in_mem[in_count_m1[AddrWidth-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.push_reloc) begin
         out_mem[out_count_ff[AddrWidth-1:0]] <= {reloc_val, reloc_push_min};
      end
      if (dp_cmd.rd_out_top) begin
         out_rd_ff <= out_mem[out_count_m1[AddrWidth-1:0]];
      end
   end

   assign rsp_status   = rsp_status_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_count    = rsp_count_ff;

endmodule

// ===== sv/min_queue_two_stacks_core.sv =====
// FIFO of signed values that also reports the smallest value held, built
// from an in-stack and an out-stack, each entry storing its value and the
// running minimum of it and the entries below it. Every request
// transaction (enqueue, dequeue, front, size, clear, min) gives exactly one
// response transaction. A command is accepted in the idle state and carried
// out in the execute state, which uses the out-stack top read (a registered
// single-port memory read). A dequeue or front that finds the out-stack
// empty first moves the N entries of the in-stack over at one per cycle,
// then refetches the top. A response that is not taken yet stalls only the
// execute cycle of the next transaction. No clearing pass after reset. The
// response count port is $clog2(DEPTH+1) bits wide (11 for the default depth).
// Depends on mqts_pkg, mqts_if, mqts_ctrl and mqts_dp.
module min_queue_two_stacks_core #(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   mqts_req_if.sink          req_chan,
   mqts_rsp_if.source        rsp_chan
);

   localparam int CountWidth = $clog2(DEPTH + 1);

   mqts_pkg::dp_cmd_type    dp_cmd;
   mqts_pkg::dp_status_type dp_status;
   logic                    req_ready;
   logic                    rsp_valid;
   mqts_pkg::status_type    rsp_status;
   logic signed [mqts_pkg::IoWidth-1:0] rsp_data_out;
   logic [CountWidth-1:0]   rsp_count;

   mqts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_cmd   (req_chan.cmd),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   mqts_dp #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_data_in  (req_chan.data_in),
      .dp_cmd       (dp_cmd),
      .dp_status    (dp_status),
      .rsp_status   (rsp_status),
      .rsp_data_out (rsp_data_out),
      .rsp_count    (rsp_count)
   );

   assign req_chan.ready    = req_ready;
   assign rsp_chan.valid    = rsp_valid;
   assign rsp_chan.status   = rsp_status;
   assign rsp_chan.data_out = rsp_data_out;
   assign rsp_chan.count    = rsp_count;

   // one transaction in flight: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while previous transaction executes");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count <= CountWidth'(DEPTH)))
      else $error("response count exceeds depth");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == mqts_pkg::STATUS_FULL) |-> (rsp_count == CountWidth'(DEPTH)))
      else $error("full status with queue not full");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == mqts_pkg::STATUS_EMPTY) |-> (rsp_count == '0))
      else $error("empty status with entries held");

endmodule

// ===== sim/min_queue_two_stacks_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench for min_queue_two_stacks_core: directed and random command streams
// checked against a two-stack queue predictor kept inside the bench.
// Depends on mqts_pkg, mqts_if and the core RTL.
module min_queue_two_stacks_core_tb;

   localparam int QUEUE_DEPTH = 1024;
   localparam int COUNT_WIDTH = 11;
   // codes the block does not define; they must act as no-ops
   localparam mqts_pkg::cmd_type CMD_SPARE_6 = 3'd6;
   localparam mqts_pkg::cmd_type CMD_SPARE_7 = 3'd7;

   typedef logic signed [mqts_pkg::IoWidth-1:0] word_type;

   typedef struct packed {
      mqts_pkg::status_type   status;
      word_type               value;
      logic [COUNT_WIDTH-1:0] count;
   } reply_type;

   logic clock;
   logic reset;
   bit   steady;     // no idling on either side while set
   int   errors;

   // predictor state: arrivals land in the inbox, departures leave the outbox
   word_type inbox_val [QUEUE_DEPTH];
   word_type inbox_min [QUEUE_DEPTH];
   word_type outbox_val [QUEUE_DEPTH];
   word_type outbox_min [QUEUE_DEPTH];
   int       inbox_n;
   int       outbox_n;
   reply_type replies_due [$];

   mqts_req_if req_chan ();
   mqts_rsp_if #(.COUNT_WIDTH(COUNT_WIDTH)) rsp_chan ();

   min_queue_two_stacks_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end

   function automatic word_type lesser(word_type a, word_type b);
      return (b < a) ? b : a;
   endfunction

   // Applies one command to the predictor and returns the reply it must give.
   function automatic reply_type apply_to_queue(mqts_pkg::cmd_type op, word_type value);
      reply_type r;
      int        total;
      r = '0;
      r.status = mqts_pkg::STATUS_OK;
      total = inbox_n + outbox_n;
      if ((op == mqts_pkg::CMD_DEQUEUE || op == mqts_pkg::CMD_FRONT ||
           op == mqts_pkg::CMD_MIN) && total == 0) begin
         r.status = mqts_pkg::STATUS_EMPTY;
      end else begin
         case (op)
            mqts_pkg::CMD_ENQUEUE: begin
               if (total >= QUEUE_DEPTH) begin
                  r.status = mqts_pkg::STATUS_FULL;
               end else begin
                  inbox_val[inbox_n] = value;
                  inbox_min[inbox_n] = (inbox_n == 0) ? value
                                       : lesser(inbox_min[inbox_n - 1], value);
                  inbox_n++;
               end
            end
            mqts_pkg::CMD_DEQUEUE, mqts_pkg::CMD_FRONT: begin
               // outbox empty: reverse the whole inbox onto it
               if (outbox_n == 0) begin
                  while (inbox_n > 0) begin
                     inbox_n--;
                     outbox_val[outbox_n] = inbox_val[inbox_n];
                     outbox_min[outbox_n] = (outbox_n == 0) ? inbox_val[inbox_n]
                                            : lesser(outbox_min[outbox_n - 1],
                                                     inbox_val[inbox_n]);
                     outbox_n++;
                  end
               end
               r.status = mqts_pkg::STATUS_VALUE;
               r.value = outbox_val[outbox_n - 1];
               if (op == mqts_pkg::CMD_DEQUEUE) outbox_n--;
            end
            mqts_pkg::CMD_CLEAR: begin
               inbox_n = 0;
               outbox_n = 0;
            end
            mqts_pkg::CMD_MIN: begin
               r.status = mqts_pkg::STATUS_VALUE;
               if (inbox_n == 0)
                  r.value = outbox_min[outbox_n - 1];
               else if (outbox_n == 0)
                  r.value = inbox_min[inbox_n - 1];
               else
                  r.value = lesser(inbox_min[inbox_n - 1], outbox_min[outbox_n - 1]);
            end
            default: ;
         endcase
      end
      r.count = COUNT_WIDTH'(inbox_n + outbox_n);
      return r;
   endfunction

   function automatic word_type pick_value();
      case ($urandom_range(9))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2, 3:    return word_type'($urandom_range(16)) - 8;
         default: return word_type'($urandom);
      endcase
   endfunction

   function automatic mqts_pkg::cmd_type pick_cmd();
      int r;
      r = $urandom_range(99);
      if (r < 43)      return mqts_pkg::CMD_ENQUEUE;
      else if (r < 65) return mqts_pkg::CMD_DEQUEUE;
      else if (r < 74) return mqts_pkg::CMD_FRONT;
      else if (r < 85) return mqts_pkg::CMD_MIN;
      else if (r < 91) return mqts_pkg::CMD_SIZE;
      else if (r < 94) return mqts_pkg::CMD_CLEAR;
      else if (r < 97) return CMD_SPARE_6;
      else             return CMD_SPARE_7;
   endfunction

   // Sends one request transaction; returns at the edge where it is accepted.
   task automatic issue(mqts_pkg::cmd_type op, word_type value);
      @(negedge clock);
      if (!steady) begin
         while ($urandom_range(99) < 13) begin
            req_chan.valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_chan.valid   <= 1'b1;
      req_chan.cmd     <= op;
      req_chan.data_in <= value;
      do @(posedge clock); while (!req_chan.ready);
      replies_due.push_back(apply_to_queue(op, value));
   endtask

   task automatic wait_for_replies();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (replies_due.size() != 0) @(negedge clock);
   endtask

   always @(negedge clock) rsp_chan.ready <= steady || ($urandom_range(99) >= 13);

   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (replies_due.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual status %0d data %0d count %0d",
                     $time, rsp_chan.status, rsp_chan.data_out, rsp_chan.count);
            errors++;
         end else begin
            want = replies_due.pop_front();
            if (rsp_chan.status !== want.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, want.status, rsp_chan.status);
               errors++;
            end
            if (rsp_chan.data_out !== want.value) begin
               $display("%0t: data_out mismatch, expected %0d, actual %0d",
                        $time, want.value, rsp_chan.data_out);
               errors++;
            end
            if (rsp_chan.count !== want.count) begin
               $display("%0t: count mismatch, expected %0d, actual %0d",
                        $time, want.count, rsp_chan.count);
               errors++;
            end
         end
      end
   end

   // every command that needs an entry, plus the no-ops, on an empty queue
   task automatic test_empty_queue();
      issue(mqts_pkg::CMD_DEQUEUE, pick_value());
      issue(mqts_pkg::CMD_FRONT, pick_value());
      issue(mqts_pkg::CMD_MIN, pick_value());
      issue(mqts_pkg::CMD_SIZE, pick_value());
      issue(mqts_pkg::CMD_CLEAR, pick_value());
      issue(CMD_SPARE_6, pick_value());
      issue(CMD_SPARE_7, pick_value());
   endtask

   // extreme values, relocation, and a minimum split across both stacks
   task automatic test_extreme_values();
      issue(mqts_pkg::CMD_ENQUEUE, 32'sh7fff_ffff);
      issue(mqts_pkg::CMD_ENQUEUE, 32'sh8000_0000);
      issue(mqts_pkg::CMD_ENQUEUE, 0);
      issue(mqts_pkg::CMD_ENQUEUE, -1);
      issue(mqts_pkg::CMD_ENQUEUE, 1);
      issue(mqts_pkg::CMD_MIN, 0);
      issue(mqts_pkg::CMD_FRONT, 0);
      issue(mqts_pkg::CMD_DEQUEUE, 0);
      issue(mqts_pkg::CMD_DEQUEUE, 0);
      issue(mqts_pkg::CMD_MIN, 0);
      issue(mqts_pkg::CMD_ENQUEUE, -5);
      issue(mqts_pkg::CMD_MIN, 0);
      issue(mqts_pkg::CMD_SIZE, 0);
      issue(mqts_pkg::CMD_DEQUEUE, 0);
      issue(mqts_pkg::CMD_DEQUEUE, 0);
      issue(mqts_pkg::CMD_DEQUEUE, 0);
      issue(mqts_pkg::CMD_MIN, 0);
      issue(mqts_pkg::CMD_DEQUEUE, 0);
      issue(mqts_pkg::CMD_DEQUEUE, 0);
   endtask

   task automatic test_random_mix(int items, bit with_pauses);
      repeat (items) begin
         issue(pick_cmd(), pick_value());
         if (with_pauses && $urandom_range(99) < 2) wait_for_replies();
      end
   endtask

   // back-to-back transactions with no idling on either side
   task automatic test_back_to_back();
      steady = 1'b1;
      test_random_mix(60, 1'b0);
      wait_for_replies();
      steady = 1'b0;
   endtask

   // fill to capacity, overflow, dequeue (relocating as needed), refill and clear
   task automatic test_fill_and_overflow();
      mqts_pkg::cmd_type peek [3];
      peek = '{mqts_pkg::CMD_MIN, mqts_pkg::CMD_FRONT, mqts_pkg::CMD_SIZE};
      while (inbox_n + outbox_n < QUEUE_DEPTH) begin
         if ($urandom_range(99) < 2)
            issue(peek[$urandom_range(2)], pick_value());
         else
            issue(mqts_pkg::CMD_ENQUEUE, pick_value());
      end
      repeat (3) issue(mqts_pkg::CMD_ENQUEUE, pick_value());
      issue(mqts_pkg::CMD_MIN, 0);
      repeat (20) issue(mqts_pkg::CMD_DEQUEUE, 0);
      repeat (5) issue(mqts_pkg::CMD_ENQUEUE, pick_value());
      issue(mqts_pkg::CMD_MIN, 0);
      issue(mqts_pkg::CMD_SIZE, 0);
      issue(mqts_pkg::CMD_CLEAR, 0);
      issue(mqts_pkg::CMD_MIN, 0);
      issue(mqts_pkg::CMD_SIZE, 0);
   endtask

   initial begin
      reset            = 1'b1;
      steady           = 1'b0;
      errors           = 0;
      inbox_n          = 0;
      outbox_n         = 0;
      req_chan.valid   = 1'b0;
      req_chan.cmd     = mqts_pkg::CMD_SIZE;
      req_chan.data_in = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_extreme_values();
      test_back_to_back();
      test_random_mix(20, 1'b1);
      wait_for_replies();
      test_fill_and_overflow();
      test_random_mix(20, 1'b1);

      wait_for_replies();
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
